// ===== hdl/tkc_pkg.sv =====
// top-k count collector: shared types, codes and constants
// no dependencies; tkc_cell and the top level refer to this package
`default_nettype none

package tkc_pkg;

  localparam int unsigned STEPS_MAX = 4;

  localparam logic [6:0] KEEP_COUNT_RESET = 7'd16;
  localparam logic [2:0] STEP_COUNT_RESET = 3'd1;

  typedef enum logic {
    CMD_OFFER  = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_KEEP_COUNT        = 2'd0,
    REG_STEP_COUNT        = 2'd1,
    REG_REQUIRE_ASCENDING = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] count_in;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [31:0] value_third;
    logic [31:0] value_fourth;
  } in_req_t;

  typedef struct packed {
    logic [31:0] rank_count;
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic [31:0] out_third;
    logic [31:0] out_fourth;
    logic        entry_valid;
    logic        last_item;
  } out_res_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [31:0]                count;
    logic [STEPS_MAX-1:0][31:0] keys;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT_DN,
    OP_SHIFT_UP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     set_valid;
    logic     valid_d;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/tkc_stream_if.sv =====
// valid/ready channel carrying one payload struct per request
// payload types come from tkc_pkg at the point of instantiation
`default_nettype none

interface tkc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tkc_cell.sv =====
// one slot of the insertion chain: holds an entry, compares it to the offer
// depends on tkc_pkg for the entry and control types
`default_nettype none

module tkc_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tkc_pkg::cell_ctrl_t ctrl_i,
  input  tkc_pkg::entry_t     new_i,
  input  tkc_pkg::entry_t     left_i,
  input  tkc_pkg::entry_t     right_i,
  input  wire  [31:0]         cnt_i,
  output tkc_pkg::entry_t     entry_o,
  output logic                valid_o,
  output logic                ge_o
);

  tkc_pkg::entry_t entry_q, entry_d;
  logic            valid_q;

  always_comb begin
    case (ctrl_i.op)
      tkc_pkg::OP_LOAD:     entry_d = new_i;
      tkc_pkg::OP_SHIFT_DN: entry_d = left_i;
      tkc_pkg::OP_SHIFT_UP: entry_d = right_i;
      default:              entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.set_valid) begin
      valid_q <= ctrl_i.valid_d;
    end
  end

  // ties keep the earlier arrival, so an equal count stays ahead
  assign ge_o    = valid_q && (entry_q.count >= cnt_i);
  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hdl/top_k_count_collector.sv =====
// top level: config registers, control of the cell chain, result register
// depends on tkc_pkg, tkc_stream_if and tkc_cell
//
//   channel  dir  payload            accepted when
//   req_i    in   tkc_pkg::in_req_t  req_i.valid && req_i.ready
//   res_o    out  tkc_pkg::out_res_t res_o.valid && res_o.ready
//   cfg_i    in   tkc_pkg::cfg_req_t cfg_i.valid && cfg_i.ready
//
// an offer is taken as it is accepted; a new request can follow in the next cycle
// a finish shifts out min(held, keep_count) entries (one empty result for an empty
// table), one entry out of the head cell per cycle unless res_o stalls
// requests are held off while the chain drains; config is always ready
// rst_ni clears the slot valid bits and the result valid flag, and resets the config registers
`default_nettype none

module top_k_count_collector #(
  parameter int unsigned K_MAX = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tkc_stream_if.sink   req_i,
  tkc_stream_if.source res_o,
  tkc_stream_if.sink   cfg_i
);

  localparam int unsigned KW = $clog2(K_MAX + 1);
  localparam int unsigned IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [6:0]     keep_count_q;
  logic [2:0]     step_count_q;
  logic           require_asc_q;
  logic [KW-1:0]  k_eff;
  logic [2:0]     s_eff;

  tkc_pkg::state_e   state_q, state_d;
  logic [IW-1:0]     drain_idx_q;
  tkc_pkg::out_res_t res_q, res_d;
  logic              res_valid_q;

  tkc_pkg::in_req_t   req;
  tkc_pkg::entry_t    new_entry;
  tkc_pkg::entry_t    cell_entry [K_MAX];
  tkc_pkg::cell_ctrl_t cell_ctrl [K_MAX];
  logic [K_MAX-1:0]   valid, ge, below_k;
  logic [K_MAX:0]     valid_up, valid_dn, ge_dn;

  logic in_acc, offer, finish, asc_ok, insert_en, pop, pop_last;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q  <= tkc_pkg::KEEP_COUNT_RESET;
      step_count_q  <= tkc_pkg::STEP_COUNT_RESET;
      require_asc_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        tkc_pkg::REG_KEEP_COUNT:        keep_count_q  <= cfg_i.data.value;
        tkc_pkg::REG_STEP_COUNT:        step_count_q  <= cfg_i.data.value[2:0];
        tkc_pkg::REG_REQUIRE_ASCENDING: require_asc_q <= cfg_i.data.value[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (keep_count_q == 7'd0) begin
      k_eff = KW'(1);
    end else if (keep_count_q > 7'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(keep_count_q);
    end
    if (step_count_q == 3'd0) begin
      s_eff = 3'd1;
    end else if (step_count_q > 3'(tkc_pkg::STEPS_MAX)) begin
      s_eff = 3'(tkc_pkg::STEPS_MAX);
    end else begin
      s_eff = step_count_q;
    end
  end

  // ---------------- request side ----------------
  assign req         = req_i.data;
  assign req_i.ready = (state_q == tkc_pkg::ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign offer       = in_acc && (req.cmd == tkc_pkg::CMD_OFFER);
  assign finish      = in_acc && (req.cmd == tkc_pkg::CMD_FINISH);

  always_comb begin
    new_entry.count   = req.count_in;
    new_entry.keys[0] = req.value_first;
    new_entry.keys[1] = (s_eff >= 3'd2) ? req.value_second : 32'd0;
    new_entry.keys[2] = (s_eff >= 3'd3) ? req.value_third  : 32'd0;
    new_entry.keys[3] = (s_eff >= 3'd4) ? req.value_fourth : 32'd0;
  end

  // star mode: used keys must rise strictly
  always_comb begin
    asc_ok = 1'b1;
    if (require_asc_q) begin
      if (s_eff >= 3'd2 && req.value_second <= req.value_first)  asc_ok = 1'b0;
      if (s_eff >= 3'd3 && req.value_third  <= req.value_second) asc_ok = 1'b0;
      if (s_eff >= 3'd4 && req.value_fourth <= req.value_third)  asc_ok = 1'b0;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    tkc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .new_i   (new_entry),
      .left_i  ((g == 0) ? new_entry : cell_entry[(g == 0) ? 0 : g - 1]),
      .right_i ((g == K_MAX - 1) ? new_entry
                                 : cell_entry[(g == K_MAX - 1) ? g : g + 1]),
      .cnt_i   (req.count_in),
      .entry_o (cell_entry[g]),
      .valid_o (valid[g]),
      .ge_o    (ge[g])
    );
  end

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      below_k[i] = (KW'(i) < k_eff);
    end
  end

  assign valid_up = {1'b0, valid};
  assign valid_dn = {valid, 1'b1};
  assign ge_dn    = {ge, 1'b1};

  // the offer lands in the first slot below keep_count that is empty or whose count is smaller
  assign insert_en = offer && asc_ok && (|(~ge & below_k));

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      tkc_pkg::ST_IDLE:  if (finish) state_d = tkc_pkg::ST_DRAIN;
      tkc_pkg::ST_DRAIN: if (pop && pop_last) state_d = tkc_pkg::ST_IDLE;
      default:           state_d = tkc_pkg::ST_IDLE;
    endcase
  end

  assign pop      = (state_q == tkc_pkg::ST_DRAIN) && (!res_valid_q || res_o.ready);
  assign pop_last = !valid[0] || !valid_up[1] || (drain_idx_q == IW'(k_eff - 1'b1));

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      cell_ctrl[i].op        = tkc_pkg::OP_HOLD;
      cell_ctrl[i].set_valid = 1'b0;
      cell_ctrl[i].valid_d   = 1'b0;
      if (insert_en) begin
        cell_ctrl[i].set_valid = 1'b1;
        cell_ctrl[i].valid_d   = below_k[i] && valid_dn[i];
        if (ge[i]) begin
          cell_ctrl[i].op = tkc_pkg::OP_HOLD;
        end else if (ge_dn[i]) begin
          cell_ctrl[i].op = tkc_pkg::OP_LOAD;
        end else begin
          cell_ctrl[i].op = tkc_pkg::OP_SHIFT_DN;
        end
      end else if (pop) begin
        cell_ctrl[i].op        = tkc_pkg::OP_SHIFT_UP;
        cell_ctrl[i].set_valid = 1'b1;
        cell_ctrl[i].valid_d   = !pop_last && valid_up[i+1];
      end
    end
  end

  always_comb begin
    res_d = '0;
    if (valid[0]) begin
      res_d.rank_count  = cell_entry[0].count;
      res_d.out_first   = cell_entry[0].keys[0];
      res_d.out_second  = (s_eff >= 3'd2) ? cell_entry[0].keys[1] : 32'd0;
      res_d.out_third   = (s_eff >= 3'd3) ? cell_entry[0].keys[2] : 32'd0;
      res_d.out_fourth  = (s_eff >= 3'd4) ? cell_entry[0].keys[3] : 32'd0;
      res_d.entry_valid = 1'b1;
    end
    res_d.last_item = pop_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkc_pkg::ST_IDLE;
      drain_idx_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        drain_idx_q <= '0;
      end else if (pop) begin
        drain_idx_q <= drain_idx_q + 1'b1;
      end
      if (pop) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire
